// ===== rtl/ekf_pkg.sv =====
// Shared constants and types of the eased keyframe interpolator.
`default_nettype none
package ekf_pkg;
   localparam int VALUE_WIDTH_DEF = 48;
   localparam int TIME_WIDTH_DEF  = 32;
   localparam int MID_W           = 16;
   localparam int RATE_W          = 17;
   localparam int FRAC_W          = 32;
   localparam int U_W             = FRAC_W + 1;
   localparam int TAU_W           = FRAC_W + 1;
   localparam int SQ_W            = 32;
   localparam int EASE_NUM_W      = 48;
   localparam int EASE_DEN_W      = MID_W + 1;
   localparam int EASE_QUO_W      = 32;
   localparam int ONE_Q           = 65536;
   localparam int PI_Q            = 205887;
   localparam int TWO_PI_Q        = 411775;
   localparam logic [MID_W-1:0] MID_RESET = 16'h8000;

   typedef logic [MID_W-1:0]  mid_type;
   typedef logic [RATE_W-1:0] rate_type;

   typedef struct packed {
      logic              zero;
      logic              accel;
      logic              below;
      logic              tau_big;
      rate_type          lin;
      logic [TAU_W-1:0]  tau;
   } ease_info_type;
endpackage
`default_nettype wire

// ===== rtl/eased_keyframe_interpolator.sv =====
// Top level of the eased keyframe interpolator.
// Usage: the csr channel writes mid_rate (Q0.16, reset 0x8000); csr_ready is always high
// and the user must make a write only while no word is in flight, as the block does not
// enforce this. Each req word carries one keyframe channel: step and elapsed time (Q16.16),
// start and end value (Q32.16), the ease flag and the blend action. Each accepted word gives
// exactly one rsp word with the eased rate (Q1.16) and the blended value, in order.
// A word passes the entry stage, the two bit-serial pipelined dividers (33 quotient bits
// for the time ratio, 32 for the ease curve), the squaring stages and the blend stages.
// Throughput is one word per cycle while rsp_ready stays high.
// Every stage holds a valid bit; when rsp_ready is low the stages fill up from the output
// backward, and req_ready falls only once every stage holds a word. Nothing is dropped.
// A synchronous reset clears all valid bits and sets mid_rate to its reset value.
`default_nettype none
module eased_keyframe_interpolator
   import ekf_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire mid_type                        csr_mid_rate,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_action,
   input  wire logic                           req_accelerate,
   input  wire logic [TIME_WIDTH-1:0]          req_step_time,
   input  wire logic [TIME_WIDTH-1:0]          req_elapsed_time,
   input  wire logic signed [VALUE_WIDTH-1:0]  req_start_value,
   input  wire logic signed [VALUE_WIDTH-1:0]  req_end_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output rate_type                            rsp_rate,
   output logic signed [VALUE_WIDTH-1:0]       rsp_value
);
   localparam int VW      = VALUE_WIDTH;
   localparam int TW      = TIME_WIDTH;
   localparam int BLEND_W = 3 * VW + 2;
   localparam int INFO_W  = $bits(ease_info_type);

   mid_type             mid_ff;
   logic                p_v_ff;
   logic [TW-1:0]       t_ff;
   logic [TW-1:0]       e_ff;
   logic                zero_ff;
   logic                accel_ff;
   logic                action_ff;
   logic                age_ff;
   logic [VW-1:0]       d_ff;
   logic [VW-1:0]       a_ff;
   logic [VW-1:0]       b_ff;
   logic                age_in;
   logic [VW-1:0]       d_in;
   logic                p_en;

   logic                lon;
   logic [VW-1:0]       mag;
   logic                tdiv_in_ready;
   logic                tdiv_valid;
   logic                tdiv_ready;
   logic [U_W-1:0]      tdiv_quo;
   logic [BLEND_W+1:0]  tdiv_side;

   logic                prep_valid;
   logic                prep_ready;
   logic [EASE_NUM_W-1:0] prep_num;
   logic [EASE_DEN_W-1:0] prep_den;
   ease_info_type       prep_info;
   logic [BLEND_W-1:0]  prep_blend;

   logic                ediv_valid;
   logic                ediv_ready;
   logic [EASE_QUO_W-1:0] ediv_quo;
   logic [INFO_W+BLEND_W-1:0] ediv_side;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= MID_RESET;
      end else if (csr_valid) begin
         mid_ff <= csr_mid_rate;
      end
   end

   assign age_in    = req_start_value >= req_end_value;
   assign d_in      = age_in ? VW'(req_start_value - req_end_value)
                             : VW'(req_end_value - req_start_value);
   assign p_en      = !p_v_ff || tdiv_in_ready;
   assign req_ready = p_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (p_en) begin
         p_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (p_en) begin
         t_ff      <= req_step_time;
         e_ff      <= (req_elapsed_time > req_step_time) ? req_step_time : req_elapsed_time;
         zero_ff   <= req_step_time == '0;
         accel_ff  <= req_accelerate;
         action_ff <= req_action;
         age_ff    <= age_in;
         d_ff      <= d_in;
         a_ff      <= req_start_value;
         b_ff      <= req_end_value;
      end
   end

   assign lon = action_ff && (d_ff > VW'(PI_Q)) && (d_ff <= VW'(TWO_PI_Q));
   assign mag = lon ? VW'(TWO_PI_Q) - d_ff : d_ff;

   ekf_div #(
      .NUM_W  (TW + FRAC_W),
      .DEN_W  (TW),
      .QUO_W  (U_W),
      .SIDE_W (BLEND_W + 2)
   ) u_time_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_v_ff),
      .in_ready  (tdiv_in_ready),
      .in_num    ({e_ff, {FRAC_W{1'b0}}}),
      .in_den    (t_ff),
      .in_side   ({zero_ff, accel_ff, lon, age_ff, mag, a_ff, b_ff}),
      .out_valid (tdiv_valid),
      .out_ready (tdiv_ready),
      .out_quo   (tdiv_quo),
      .out_side  (tdiv_side)
   );

   ekf_ease_prep #(
      .BLEND_W (BLEND_W)
   ) u_ease_prep (
      .clock     (clock),
      .reset     (reset),
      .mid_rate  (mid_ff),
      .in_valid  (tdiv_valid),
      .in_ready  (tdiv_ready),
      .in_u      (tdiv_quo),
      .in_side   (tdiv_side),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_num   (prep_num),
      .out_den   (prep_den),
      .out_info  (prep_info),
      .out_blend (prep_blend)
   );

   ekf_div #(
      .NUM_W  (EASE_NUM_W),
      .DEN_W  (EASE_DEN_W),
      .QUO_W  (EASE_QUO_W),
      .SIDE_W (INFO_W + BLEND_W)
   ) u_ease_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_num    (prep_num),
      .in_den    (prep_den),
      .in_side   ({prep_info, prep_blend}),
      .out_valid (ediv_valid),
      .out_ready (ediv_ready),
      .out_quo   (ediv_quo),
      .out_side  (ediv_side)
   );

   ekf_blend #(
      .VALUE_WIDTH (VW)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .mid_rate  (mid_ff),
      .in_valid  (ediv_valid),
      .in_ready  (ediv_ready),
      .in_quo    (ediv_quo),
      .in_info   (ediv_side[INFO_W+BLEND_W-1:BLEND_W]),
      .in_blend  (ediv_side[BLEND_W-1:0]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rate  (rsp_rate),
      .out_value (rsp_value)
   );
endmodule
`default_nettype wire

// ===== rtl/ekf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data.
`default_nettype none
module ekf_div
   import ekf_pkg::*;
#(
   parameter int NUM_W  = TIME_WIDTH_DEF + FRAC_W,
   parameter int DEN_W  = TIME_WIDTH_DEF,
   parameter int QUO_W  = U_W,
   parameter int SIDE_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [QUO_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]      out_side
);
   logic [DEN_W-1:0]  rem_ff  [QUO_W+1];
   logic [QUO_W-1:0]  low_ff  [QUO_W+1];
   logic [QUO_W-1:0]  quo_ff  [QUO_W+1];
   logic [DEN_W-1:0]  den_ff  [QUO_W+1];
   logic [SIDE_W-1:0] side_ff [QUO_W+1];
   logic              v_ff    [QUO_W+1];
   logic [QUO_W+1:0]  en;

   assign en[QUO_W+1] = out_ready;

   for (genvar k = 0; k <= QUO_W; k++) begin : g_stage
      assign en[k] = !v_ff[k] || en[k+1];
      if (k == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en[k]) begin
               v_ff[k] <= in_valid;
            end
         end
         always_ff @(posedge clock) begin
            if (en[k]) begin
               rem_ff[k]  <= DEN_W'(in_num[NUM_W-1:QUO_W]);
               low_ff[k]  <= in_num[QUO_W-1:0];
               quo_ff[k]  <= '0;
               den_ff[k]  <= in_den;
               side_ff[k] <= in_side;
            end
         end
      end else begin : g_step
         logic [DEN_W:0]   trial;
         logic             ge;
         logic [DEN_W-1:0] rem_in;
         assign trial  = {rem_ff[k-1], low_ff[k-1][QUO_W-1]};
         assign ge     = trial >= {1'b0, den_ff[k-1]};
         assign rem_in = ge ? DEN_W'(trial - {1'b0, den_ff[k-1]}) : DEN_W'(trial);
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en[k]) begin
               rem_ff[k]  <= rem_in;
               low_ff[k]  <= {low_ff[k-1][QUO_W-2:0], 1'b0};
               quo_ff[k]  <= {quo_ff[k-1][QUO_W-2:0], ge};
               den_ff[k]  <= den_ff[k-1];
               side_ff[k] <= side_ff[k-1];
            end
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];
endmodule
`default_nettype wire

// ===== rtl/ekf_ease_prep.sv =====
// Ease branch selection and squaring ahead of the ease divider.
`default_nettype none
module ekf_ease_prep
   import ekf_pkg::*;
#(
   parameter int BLEND_W = 3 * VALUE_WIDTH_DEF + 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mid_type              mid_rate,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [U_W-1:0]       in_u,
   input  wire logic [BLEND_W+1:0]   in_side,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [EASE_NUM_W-1:0]     out_num,
   output logic [EASE_DEN_W-1:0]     out_den,
   output ease_info_type             out_info,
   output logic [BLEND_W-1:0]        out_blend
);
   logic [U_W-1:0]      mm;
   logic [TAU_W-1:0]    kk;
   ease_info_type       info_in;
   logic [SQ_W-1:0]     sq_in;
   logic [2*SQ_W-1:0]   prod_in;

   logic                e1_v_ff;
   ease_info_type       e1_info_ff;
   logic [SQ_W-1:0]     e1_sq_ff;
   logic [BLEND_W-1:0]  e1_blend_ff;
   logic                e2_v_ff;
   ease_info_type       e2_info_ff;
   logic [2*SQ_W-1:0]   e2_prod_ff;
   logic [BLEND_W-1:0]  e2_blend_ff;
   logic                en1;
   logic                en2;

   assign mm = {1'b0, mid_rate, 16'b0};
   assign kk = {(EASE_DEN_W'(ONE_Q) - {1'b0, mid_rate}), 16'b0};

   always_comb begin
      info_in.zero    = in_side[BLEND_W+1];
      info_in.accel   = in_side[BLEND_W];
      info_in.below   = in_u < mm;
      info_in.tau     = in_u - mm;
      info_in.tau_big = !info_in.below && (info_in.tau >= kk);
      info_in.lin     = RATE_W'(in_u >> 16);
      sq_in           = info_in.below ? in_u[SQ_W-1:0] : info_in.tau[SQ_W-1:0];
   end

   assign prod_in = 64'(e1_sq_ff) * 64'(e1_sq_ff);

   assign en2      = !e2_v_ff || out_ready;
   assign en1      = !e1_v_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_v_ff <= 1'b0;
         e2_v_ff <= 1'b0;
      end else begin
         if (en1) begin
            e1_v_ff <= in_valid;
         end
         if (en2) begin
            e2_v_ff <= e1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         e1_info_ff  <= info_in;
         e1_sq_ff    <= sq_in;
         e1_blend_ff <= in_side[BLEND_W-1:0];
      end
      if (en2) begin
         e2_info_ff  <= e1_info_ff;
         e2_prod_ff  <= prod_in;
         e2_blend_ff <= e1_blend_ff;
      end
   end

   assign out_valid = e2_v_ff;
   assign out_num   = e2_info_ff.below ? EASE_NUM_W'(e2_prod_ff[2*SQ_W-1:32])
                                       : e2_prod_ff[2*SQ_W-1:16];
   assign out_den   = e2_info_ff.below ? {1'b0, mid_rate}
                                       : EASE_DEN_W'(ONE_Q) - {1'b0, mid_rate};
   assign out_info  = e2_info_ff;
   assign out_blend = e2_blend_ff;
endmodule
`default_nettype wire

// ===== rtl/ekf_blend.sv =====
// Rate finish, magnitude scaling and plain or longitude blend stages.
`default_nettype none
module ekf_blend
   import ekf_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mid_type                    mid_rate,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [EASE_QUO_W-1:0]      in_quo,
   input  wire ease_info_type              in_info,
   input  wire logic [3*VALUE_WIDTH+1:0]   in_blend,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output rate_type                        out_rate,
   output logic signed [VALUE_WIDTH-1:0]   out_value
);
   localparam int VW   = VALUE_WIDTH;
   localparam int LO_W = (VW + 1) / 2;
   localparam int HI_W = VW - LO_W;
   localparam int SW   = VW + 2;
   localparam logic signed [SW-1:0] VMAX   = {3'b000, {(VW-1){1'b1}}};
   localparam logic signed [SW-1:0] VMIN   = {3'b111, {(VW-1){1'b0}}};
   localparam logic signed [SW-1:0] PI_S   = SW'(PI_Q);
   localparam logic signed [SW-1:0] TWO_PI = SW'(TWO_PI_Q);
   localparam rate_type             ONE_R  = RATE_W'(ONE_Q);

   function automatic logic [VW-1:0] sat(input logic signed [SW-1:0] x);
      logic [VW-1:0] r;
      if (x > VMAX) begin
         r = VMAX[VW-1:0];
      end else if (x < VMIN) begin
         r = VMIN[VW-1:0];
      end else begin
         r = x[VW-1:0];
      end
      return r;
   endfunction

   logic              in_lon;
   logic              in_age;
   logic [VW-1:0]     in_mag;
   logic [VW-1:0]     in_a;
   logic [VW-1:0]     in_b;
   logic [34:0]       r_sum;
   logic [34:0]       r_sub;
   logic [18:0]       r_hi;
   rate_type          rate_in;

   logic              v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic              en0, en1, en2, en3, en4;
   rate_type          rate0_ff, rate1_ff, rate2_ff, rate3_ff, rate4_ff;
   logic              lon0_ff, lon1_ff, lon2_ff, lon3_ff;
   logic              age0_ff, age1_ff, age2_ff, age3_ff;
   logic [VW-1:0]     mag0_ff, mag1_ff, mag2_ff;
   logic [VW-1:0]     a0_ff, a1_ff, a2_ff;
   logic [VW-1:0]     b0_ff, b1_ff, b2_ff, b3_ff;
   logic [HI_W+RATE_W-1:0] hi_in, hi1_ff;
   logic [LO_W+RATE_W-1:0] lo_in, lo1_ff;
   logic [VW+RATE_W-1:0]   prod_sum;
   logic [VW-1:0]     off_in, off2_ff;
   logic [VW-1:0]     plain_in, plain3_ff;
   logic signed [SW-1:0] a_s;
   logic signed [SW-1:0] lon_raw;
   logic [VW-1:0]     lon_in, lonv3_ff;
   logic signed [SW-1:0] l3_s;
   logic [VW-1:0]     wrap_in;
   logic [VW-1:0]     value_in, value4_ff;

   assign in_b   = in_blend[VW-1:0];
   assign in_a   = in_blend[2*VW-1:VW];
   assign in_mag = in_blend[3*VW-1:2*VW];
   assign in_age = in_blend[3*VW];
   assign in_lon = in_blend[3*VW+1];

   always_comb begin
      r_sub   = in_info.tau_big ? 35'(in_info.tau) : 35'(in_quo);
      r_sum   = 35'({mid_rate, 16'b0}) + (35'(in_info.tau) << 1) - r_sub;
      r_hi    = r_sum[34:16];
      if (in_info.zero) begin
         rate_in = ONE_R;
      end else if (!in_info.accel) begin
         rate_in = in_info.lin;
      end else if (in_info.below) begin
         rate_in = (in_quo > 32'(ONE_Q)) ? ONE_R : RATE_W'(in_quo);
      end else begin
         rate_in = (r_hi > 19'(ONE_Q)) ? ONE_R : r_hi[RATE_W-1:0];
      end
   end

   assign hi_in    = (HI_W+RATE_W)'(mag0_ff[VW-1:LO_W]) * (HI_W+RATE_W)'(rate0_ff);
   assign lo_in    = (LO_W+RATE_W)'(mag0_ff[LO_W-1:0]) * (LO_W+RATE_W)'(rate0_ff);
   assign prod_sum = {hi1_ff, {LO_W{1'b0}}} + (VW+RATE_W)'(lo1_ff);
   assign off_in   = VW'(prod_sum >> 16);

   always_comb begin
      a_s      = SW'(signed'(a2_ff));
      plain_in = age2_ff ? a2_ff - off2_ff : a2_ff + off2_ff;
      lon_raw  = age2_ff ? a_s + SW'(off2_ff) : a_s - SW'(off2_ff);
      lon_in   = sat(lon_raw);
   end

   always_comb begin
      l3_s = SW'(signed'(lonv3_ff));
      if (l3_s > PI_S || l3_s < -PI_S) begin
         wrap_in = age3_ff ? sat(l3_s - TWO_PI) : sat(l3_s + TWO_PI);
      end else begin
         wrap_in = lonv3_ff;
      end
      if (!lon3_ff) begin
         value_in = plain3_ff;
      end else if (rate3_ff == ONE_R) begin
         value_in = b3_ff;
      end else begin
         value_in = wrap_in;
      end
   end

   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign en0      = !v0_ff || en1;
   assign in_ready = en0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en0) begin
            v0_ff <= in_valid;
         end
         if (en1) begin
            v1_ff <= v0_ff;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         rate0_ff <= rate_in;
         lon0_ff  <= in_lon;
         age0_ff  <= in_age;
         mag0_ff  <= in_mag;
         a0_ff    <= in_a;
         b0_ff    <= in_b;
      end
      if (en1) begin
         hi1_ff   <= hi_in;
         lo1_ff   <= lo_in;
         rate1_ff <= rate0_ff;
         lon1_ff  <= lon0_ff;
         age1_ff  <= age0_ff;
         mag1_ff  <= mag0_ff;
         a1_ff    <= a0_ff;
         b1_ff    <= b0_ff;
      end
      if (en2) begin
         off2_ff  <= off_in;
         rate2_ff <= rate1_ff;
         lon2_ff  <= lon1_ff;
         age2_ff  <= age1_ff;
         mag2_ff  <= mag1_ff;
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
      end
      if (en3) begin
         plain3_ff <= plain_in;
         lonv3_ff  <= lon_in;
         rate3_ff  <= rate2_ff;
         lon3_ff   <= lon2_ff;
         age3_ff   <= age2_ff;
         b3_ff     <= b2_ff;
      end
      if (en4) begin
         value4_ff <= value_in;
         rate4_ff  <= rate3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_rate  = rate4_ff;
   assign out_value = signed'(value4_ff);

   a_rate_bound: assert property (@(posedge clock) disable iff (reset)
      v0_ff |-> rate0_ff <= ONE_R)
      else $error("Rate exceeds one.");

   a_off_bound: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> off2_ff <= mag2_ff)
      else $error("Scaled offset exceeds its magnitude.");

   a_full_rate_end: assert property (@(posedge clock) disable iff (reset)
      (en4 && v3_ff && rate3_ff == ONE_R) |=> value4_ff == $past(b3_ff))
      else $error("Full rate does not give the end value.");
endmodule
`default_nettype wire
